>>> hdl/pnmsd_pkg.sv
// shared constants, codes and helpers for the pnm stream decoder
package pnmsd_pkg;

	localparam int MAX_DIM_DEFAULT = 4096;

	// parse phase, one-hot
	typedef enum logic [8:0] {
		PH_SIG      = 9'b000000001,
		PH_WIDTH    = 9'b000000010,
		PH_HEIGHT   = 9'b000000100,
		PH_MAXVAL   = 9'b000001000,
		PH_SKIPLINE = 9'b000010000,
		PH_TEXTPIX  = 9'b000100000,
		PH_BINPIX   = 9'b001000000,
		PH_DONE     = 9'b010000000,
		PH_ERROR    = 9'b100000000
	} phase_t;

	// work steps for one input beat, one-hot
	typedef enum logic [2:0] {
		SEQ_MAIN = 3'b001,
		SEQ_TOK  = 3'b010,
		SEQ_END  = 3'b100
	} seq_t;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_FINAL  = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_SIG    = 3'd0;
	localparam logic [2:0] ERR_SIZE   = 3'd1;
	localparam logic [2:0] ERR_MAXVAL = 3'd2;
	localparam logic [2:0] ERR_PIXEL  = 3'd3;
	localparam logic [2:0] ERR_EOF    = 3'd4;

	localparam logic [2:0] FMT_P1 = 3'd1;
	localparam logic [2:0] FMT_P2 = 3'd2;
	localparam logic [2:0] FMT_P3 = 3'd3;
	localparam logic [2:0] FMT_P4 = 3'd4;
	localparam logic [2:0] FMT_P5 = 3'd5;
	localparam logic [2:0] FMT_P6 = 3'd6;

	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_1    = 8'h31;
	localparam logic [7:0] CH_6    = 8'h36;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_VT   = 8'h0B;
	localparam logic [7:0] CH_FF   = 8'h0C;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;

	localparam logic [15:0] MAXVAL_LIMIT = 16'd255;
	localparam logic [15:0] SIG_DONE     = 16'd2;
	localparam logic [15:0] SIG_HAVE_P   = 16'd1;

	function automatic logic is_space(logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
			c == CH_CR;
	endfunction

	function automatic logic is_text(phase_t p);
		return p == PH_SIG || p == PH_WIDTH || p == PH_HEIGHT || p == PH_MAXVAL ||
			p == PH_TEXTPIX;
	endfunction

endpackage

>>> hdl/pnm_stream_decoder.sv
// pnm stream decoder top level: header parse, pixel unpack, result staging
// Takes a P1..P6 netpbm file one byte per beat and returns a header beat, then
// one beat per pixel with its column and row (the final pixel marked), or an
// error beat; last marks the final result caused by an input byte. Ordinary
// bytes are taken at one per cycle unless a full output stalls the decode. A P4
// data byte holds the input while it unpacks its pixels (up to 8), and the byte
// flagged end_of_file is followed by a token flush step, then the end check and
// return to the idle state. All of this runs through the single decode step,
// which handles one input byte or one P4 bit and produces at most one result per
// cycle. A result passes from its byte in the decode register to the hold register
// and then the output register. The hold register keeps a result until it is known
// whether more results of the same byte follow, so last is always exact.
module pnm_stream_decoder #(
	parameter int MAX_DIM = pnmsd_pkg::MAX_DIM_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [2:0]  format,
	output logic [12:0] width,
	output logic [12:0] height,
	output logic [7:0]  max_value,
	output logic [11:0] column,
	output logic [11:0] row,
	output logic [7:0]  red_or_gray,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [2:0]  error_code,
	output logic        last
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int CMP_W = DIM_W + 1;

	// decoder state
	typedef struct packed {
		pnmsd_pkg::phase_t  phase;
		logic [2:0]         fmt;
		logic [DIM_W-1:0]   wid;
		logic [DIM_W-1:0]   hgt;
		logic [7:0]         maxv;
		logic [15:0]        tval;
		logic               tok;
		logic               cmt;
		logic [CNT_W-1:0]   col;
		logic [CNT_W-1:0]   row;
		logic [1:0]         chan;
		logic [15:0]        pcol;
	} dec_state_t;

	// one result beat
	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  fmt;
		logic [12:0] wid;
		logic [12:0] hgt;
		logic [7:0]  maxv;
		logic [11:0] col;
		logic [11:0] row;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [2:0]  err;
	} res_t;

	// outcome of one decode step
	typedef struct packed {
		dec_state_t s;
		logic       gen;
		res_t       r;
	} work_t;

	function automatic dec_state_t f_reset();
		dec_state_t s;
		s = '0;
		s.phase = pnmsd_pkg::PH_SIG;
		return s;
	endfunction

	function automatic logic f_final(dec_state_t s);
		return CMP_W'(s.col) + CMP_W'(1) >= CMP_W'(s.wid) &&
			CMP_W'(s.row) + CMP_W'(1) >= CMP_W'(s.hgt);
	endfunction

	function automatic work_t f_put(work_t x, logic [1:0] k, logic [11:0] c, logic [11:0] rw,
			logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [2:0] e);
		x.gen    = 1'b1;
		x.r.kind = k;
		x.r.fmt  = x.s.fmt;
		x.r.wid  = 13'(x.s.wid);
		x.r.hgt  = 13'(x.s.hgt);
		x.r.maxv = x.s.maxv;
		x.r.col  = c;
		x.r.row  = rw;
		x.r.r    = r;
		x.r.g    = g;
		x.r.b    = b;
		x.r.err  = e;
		return x;
	endfunction

	function automatic work_t f_fail(work_t x, logic [2:0] e);
		x = f_put(x, pnmsd_pkg::KIND_ERROR, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, e);
		x.s.phase = pnmsd_pkg::PH_ERROR;
		x.s.tok   = 1'b0;
		x.s.cmt   = 1'b0;
		x.s.tval  = '0;
		return x;
	endfunction

	function automatic work_t f_pixel(work_t x, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		logic fin;
		logic wrap;
		fin  = f_final(x.s);
		wrap = CMP_W'(x.s.col) + CMP_W'(1) >= CMP_W'(x.s.wid);
		x = f_put(x, fin ? pnmsd_pkg::KIND_FINAL : pnmsd_pkg::KIND_PIXEL, 12'(x.s.col),
			12'(x.s.row), r, g, b, pnmsd_pkg::ERR_NONE);
		if (fin) begin
			x.s.phase = pnmsd_pkg::PH_DONE;
		end else if (wrap) begin
			x.s.col = '0;
			x.s.row = x.s.row + CNT_W'(1);
		end else begin
			x.s.col = x.s.col + CNT_W'(1);
		end
		return x;
	endfunction

	function automatic work_t f_begin(work_t x, pnmsd_pkg::phase_t p);
		x.s.phase = p;
		x.s.col   = '0;
		x.s.row   = '0;
		x.s.chan  = '0;
		x.s.pcol  = '0;
		return x;
	endfunction

	function automatic work_t f_color(work_t x, logic [7:0] v);
		if (x.s.chan == 2'd0) begin
			x.s.pcol = {8'd0, v};
			x.s.chan = 2'd1;
		end else if (x.s.chan == 2'd1) begin
			x.s.pcol = {v, x.s.pcol[7:0]};
			x.s.chan = 2'd2;
		end else begin
			x.s.chan = 2'd0;
			x = f_pixel(x, x.s.pcol[7:0], x.s.pcol[15:8], v);
			x.s.pcol = '0;
		end
		return x;
	endfunction

	function automatic work_t f_finish(work_t x, logic [7:0] delim);
		logic [15:0] v;
		logic        bad_dim;
		pnmsd_pkg::phase_t bin_ph;
		v = x.s.tval;
		bad_dim = (v == 16'd0) || (32'(v) > 32'(MAX_DIM));
		bin_ph = (delim == pnmsd_pkg::CH_LF) ? pnmsd_pkg::PH_BINPIX : pnmsd_pkg::PH_SKIPLINE;
		x.s.tval = '0;
		x.s.tok  = 1'b0;
		unique case (x.s.phase)
			pnmsd_pkg::PH_SIG: begin
				if (v != pnmsd_pkg::SIG_DONE) x = f_fail(x, pnmsd_pkg::ERR_SIG);
				else x.s.phase = pnmsd_pkg::PH_WIDTH;
			end
			pnmsd_pkg::PH_WIDTH: begin
				if (bad_dim) begin
					x = f_fail(x, pnmsd_pkg::ERR_SIZE);
				end else begin
					x.s.wid   = DIM_W'(v);
					x.s.phase = pnmsd_pkg::PH_HEIGHT;
				end
			end
			pnmsd_pkg::PH_HEIGHT: begin
				if (bad_dim) begin
					x = f_fail(x, pnmsd_pkg::ERR_SIZE);
				end else begin
					x.s.hgt = DIM_W'(v);
					if (x.s.fmt == pnmsd_pkg::FMT_P1 || x.s.fmt == pnmsd_pkg::FMT_P4) begin
						x.s.maxv = 8'd1;
						x = f_put(x, pnmsd_pkg::KIND_HEADER, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0,
							pnmsd_pkg::ERR_NONE);
						if (x.s.fmt == pnmsd_pkg::FMT_P4) x = f_begin(x, bin_ph);
						else x = f_begin(x, pnmsd_pkg::PH_TEXTPIX);
					end else begin
						x.s.phase = pnmsd_pkg::PH_MAXVAL;
					end
				end
			end
			pnmsd_pkg::PH_MAXVAL: begin
				if (v == 16'd0 || v > pnmsd_pkg::MAXVAL_LIMIT) begin
					x = f_fail(x, pnmsd_pkg::ERR_MAXVAL);
				end else begin
					x.s.maxv = v[7:0];
					x = f_put(x, pnmsd_pkg::KIND_HEADER, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0,
						pnmsd_pkg::ERR_NONE);
					if (x.s.fmt == pnmsd_pkg::FMT_P2 || x.s.fmt == pnmsd_pkg::FMT_P3)
						x = f_begin(x, pnmsd_pkg::PH_TEXTPIX);
					else
						x = f_begin(x, bin_ph);
				end
			end
			pnmsd_pkg::PH_TEXTPIX: begin
				if (v > pnmsd_pkg::MAXVAL_LIMIT) x = f_fail(x, pnmsd_pkg::ERR_PIXEL);
				else if (x.s.fmt == pnmsd_pkg::FMT_P3) x = f_color(x, v[7:0]);
				else x = f_pixel(x, v[7:0], 8'd0, 8'd0);
			end
			default: begin
			end
		endcase
		return x;
	endfunction

	function automatic work_t f_text_byte(work_t x, logic [7:0] c);
		logic [7:0]  dig;
		logic [20:0] acc;
		dig = c - pnmsd_pkg::CH_0;
		acc = 21'(x.s.tval) * 21'd10 + 21'(dig[3:0]);
		if (x.s.cmt) begin
			if (c == pnmsd_pkg::CH_LF) x.s.cmt = 1'b0;
			return x;
		end
		if (pnmsd_pkg::is_space(c) || c == pnmsd_pkg::CH_HASH) begin
			if (x.s.tok) x = f_finish(x, c);
			if (c == pnmsd_pkg::CH_HASH && pnmsd_pkg::is_text(x.s.phase)) x.s.cmt = 1'b1;
			return x;
		end
		if (x.s.phase == pnmsd_pkg::PH_TEXTPIX && x.s.fmt == pnmsd_pkg::FMT_P1) begin
			if (c == pnmsd_pkg::CH_0 || c == pnmsd_pkg::CH_1)
				x = f_pixel(x, {7'd0, c[0]}, 8'd0, 8'd0);
			else
				x = f_fail(x, pnmsd_pkg::ERR_PIXEL);
			return x;
		end
		x.s.tok = 1'b1;
		if (x.s.phase == pnmsd_pkg::PH_SIG) begin
			if (x.s.tval == 16'd0 && c == pnmsd_pkg::CH_P) begin
				x.s.tval = pnmsd_pkg::SIG_HAVE_P;
			end else if (x.s.tval == pnmsd_pkg::SIG_HAVE_P && c >= pnmsd_pkg::CH_1 &&
					c <= pnmsd_pkg::CH_6) begin
				x.s.fmt  = dig[2:0];
				x.s.tval = pnmsd_pkg::SIG_DONE;
			end else begin
				x = f_fail(x, pnmsd_pkg::ERR_SIG);
			end
			return x;
		end
		if (c < pnmsd_pkg::CH_0 || c > pnmsd_pkg::CH_9) begin
			if (x.s.phase == pnmsd_pkg::PH_MAXVAL) x = f_fail(x, pnmsd_pkg::ERR_MAXVAL);
			else if (x.s.phase == pnmsd_pkg::PH_TEXTPIX) x = f_fail(x, pnmsd_pkg::ERR_PIXEL);
			else x = f_fail(x, pnmsd_pkg::ERR_SIZE);
			return x;
		end
		x.s.tval = (acc > 21'h00FFFF) ? 16'hFFFF : acc[15:0];
		return x;
	endfunction

	// decode register: the beat under work and its step
	logic              s1_valid;
	logic [7:0]        byte_s1;
	logic              eof_s1;
	pnmsd_pkg::seq_t   seq_s1;
	logic [2:0]        bit_s1;

	dec_state_t        state_q;

	// hold register: newest result, sealed once its last flag is known
	logic              hold_valid_q;
	logic              hold_sealed_q;
	res_t              hold_res_q;

	// output register
	logic              out_valid_q;
	res_t              out_res_q;
	logic              out_last_q;

	work_t             x;
	pnmsd_pkg::seq_t   nxt_seq;
	logic [2:0]        nxt_bit;
	logic              fin;
	logic              more;
	logic              o_free;
	logic              step_en;
	logic              hold_move;
	logic              in_take;

	// one decode step: the byte itself, one P4 bit, or an end-of-file action
	always_comb begin
		x.s     = state_q;
		x.gen   = 1'b0;
		x.r     = '0;
		nxt_seq = seq_s1;
		nxt_bit = bit_s1;
		fin     = 1'b0;
		more    = 1'b0;
		unique case (seq_s1)
			pnmsd_pkg::SEQ_MAIN: begin
				if (pnmsd_pkg::is_text(state_q.phase)) begin
					x = f_text_byte(x, byte_s1);
				end else if (state_q.phase == pnmsd_pkg::PH_SKIPLINE) begin
					if (byte_s1 == pnmsd_pkg::CH_LF) x.s.phase = pnmsd_pkg::PH_BINPIX;
				end else if (state_q.phase == pnmsd_pkg::PH_BINPIX) begin
					if (state_q.fmt == pnmsd_pkg::FMT_P5) begin
						x = f_pixel(x, byte_s1, 8'd0, 8'd0);
					end else if (state_q.fmt == pnmsd_pkg::FMT_P6) begin
						x = f_color(x, byte_s1);
					end else begin
						// msb first; a row wrap ends the byte, the rest is padding
						x = f_pixel(x, {7'd0, byte_s1[3'd7 - bit_s1]}, 8'd0, 8'd0);
						// on an early end only seven pixels come from the last byte
						more = x.s.phase == pnmsd_pkg::PH_BINPIX && x.s.col != '0 &&
							bit_s1 != 3'd7 && (bit_s1 != 3'd6 || !eof_s1 || f_final(x.s));
					end
				end
				if (more) begin
					nxt_bit = bit_s1 + 3'd1;
				end else if (eof_s1) begin
					nxt_seq = pnmsd_pkg::SEQ_TOK;
					nxt_bit = 3'd0;
				end else begin
					fin = 1'b1;
				end
			end
			pnmsd_pkg::SEQ_TOK: begin
				// a token cut off by the end of file ends as if a newline followed
				if (state_q.tok && pnmsd_pkg::is_text(state_q.phase))
					x = f_finish(x, pnmsd_pkg::CH_LF);
				nxt_seq = pnmsd_pkg::SEQ_END;
			end
			pnmsd_pkg::SEQ_END: begin
				if (state_q.phase != pnmsd_pkg::PH_DONE && state_q.phase != pnmsd_pkg::PH_ERROR)
					x = f_fail(x, pnmsd_pkg::ERR_EOF);
				x.s = f_reset();
				fin = 1'b1;
			end
			default: begin
				fin = 1'b1;
			end
		endcase
	end

	// handshake and staging control
	assign o_free    = !out_valid_q || out_ready;
	assign step_en   = s1_valid && (!hold_valid_q || o_free);
	assign hold_move = hold_valid_q && o_free && (hold_sealed_q || (step_en && (x.gen || fin)));
	assign in_ready  = !s1_valid || (step_en && fin);
	assign in_take   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid      <= 1'b0;
			seq_s1        <= pnmsd_pkg::SEQ_MAIN;
			bit_s1        <= 3'd0;
			state_q       <= f_reset();
			hold_valid_q  <= 1'b0;
			hold_sealed_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_take) begin
				s1_valid <= 1'b1;
				seq_s1   <= pnmsd_pkg::SEQ_MAIN;
				bit_s1   <= 3'd0;
			end else if (step_en && fin) begin
				s1_valid <= 1'b0;
			end else if (step_en) begin
				seq_s1 <= nxt_seq;
				bit_s1 <= nxt_bit;
			end
			if (step_en) state_q <= x.s;
			if (step_en && x.gen) begin
				hold_valid_q  <= 1'b1;
				hold_sealed_q <= fin;
			end else if (hold_move) begin
				hold_valid_q  <= 1'b0;
				hold_sealed_q <= 1'b0;
			end
			if (hold_move) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
		if (step_en && x.gen) hold_res_q <= x.r;
		if (hold_move) begin
			out_res_q  <= hold_res_q;
			// an unsealed result is last unless this step brought another one
			out_last_q <= hold_sealed_q || !x.gen;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_res_q.kind;
	assign format      = out_res_q.fmt;
	assign width       = out_res_q.wid;
	assign height      = out_res_q.hgt;
	assign max_value   = out_res_q.maxv;
	assign column      = out_res_q.col;
	assign row         = out_res_q.row;
	assign red_or_gray = out_res_q.r;
	assign green       = out_res_q.g;
	assign blue        = out_res_q.b;
	assign error_code  = out_res_q.err;
	assign last        = out_last_q;

	// an error or the final pixel closes the work of its byte
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == pnmsd_pkg::KIND_ERROR || kind == pnmsd_pkg::KIND_FINAL) |-> last)
		else $error("error or final pixel beat without last");

	// an unsealed result only waits while its byte is still under work
	a_hold_owner: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q && !hold_sealed_q |-> s1_valid)
		else $error("unsealed hold result without a byte in work");

	// only the end-of-file byte gets the flush steps
	a_eof_steps: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && seq_s1 != pnmsd_pkg::SEQ_MAIN |-> eof_s1)
		else $error("end-of-file step on an ordinary byte");

	// a sealed hold result leaves as soon as the output register frees
	a_hold_drain: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q && hold_sealed_q && !(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("sealed result not passed to output");

endmodule

>>> bench/tb_pnm_stream_decoder.sv
// testbench for the pnm stream decoder: byte streams in, predicted result beats checked
`timescale 1ns / 100ps

module tb_pnm_stream_decoder;

	localparam int LIMIT_CYCLES = 600000;
	localparam int DIM_LIMIT = pnmsd_pkg::MAX_DIM_DEFAULT;

	// decoder parse state as the predictor tracks it
	typedef enum int {
		S_SIG, S_WIDTH, S_HEIGHT, S_MAXVAL, S_SKIPLINE, S_TEXTPIX, S_BINPIX, S_DONE, S_ERROR
	} parse_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  fmt;
		logic [12:0] w;
		logic [12:0] h;
		logic [7:0]  mv;
		logic [11:0] col;
		logic [11:0] row;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [2:0]  err;
		logic        last;
	} pnm_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        end_of_file = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [2:0]  format;
	logic [12:0] width;
	logic [12:0] height;
	logic [7:0]  max_value;
	logic [11:0] column;
	logic [11:0] row;
	logic [7:0]  red_or_gray;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [2:0]  error_code;
	logic        last;

	pnm_stream_decoder uut (.*);

	always #5 clk = ~clk;

	// idling controls and pressure
	int send_idle = 0;
	int recv_idle = 0;
	int hold_off = 0;
	int mismatches = 0;
	int cycles = 0;
	int bytes_sent = 0;
	int files_sent = 0;
	int beats_seen = 0;

	pnm_beat_t pending_beats[$];
	pnm_beat_t byte_beats[$];
	logic [7:0] file_buf[$];

	// decoder shadow state
	parse_t ps;
	int p_fmt, p_w, p_h, p_mv, tok_val, col_cnt, row_cnt, chan, part;
	bit in_tok, in_cmt;

	function automatic void shadow_reset();
		ps = S_SIG;
		p_fmt = 0; p_w = 0; p_h = 0; p_mv = 0; tok_val = 0;
		col_cnt = 0; row_cnt = 0; chan = 0; part = 0;
		in_tok = 0; in_cmt = 0;
	endfunction

	function automatic bit white(logic [7:0] c);
		return c == pnmsd_pkg::CH_SP || c == pnmsd_pkg::CH_TAB || c == pnmsd_pkg::CH_LF ||
			c == pnmsd_pkg::CH_VT || c == pnmsd_pkg::CH_FF || c == pnmsd_pkg::CH_CR;
	endfunction

	function automatic bit text_state();
		return ps == S_SIG || ps == S_WIDTH || ps == S_HEIGHT || ps == S_MAXVAL ||
			ps == S_TEXTPIX;
	endfunction

	function automatic void emit(logic [1:0] k, int c, int r, int rv, int gv, int bv,
			logic [2:0] e);
		pnm_beat_t t;
		if (byte_beats.size() >= 8)
			return;
		t.kind = k; t.fmt = 3'(p_fmt); t.w = 13'(p_w); t.h = 13'(p_h); t.mv = 8'(p_mv);
		t.col = 12'(c); t.row = 12'(r); t.r = 8'(rv); t.g = 8'(gv); t.b = 8'(bv);
		t.err = e; t.last = 1'b0;
		byte_beats.push_back(t);
	endfunction

	function automatic void raise_error(logic [2:0] e);
		emit(pnmsd_pkg::KIND_ERROR, 0, 0, 0, 0, 0, e);
		ps = S_ERROR;
		in_tok = 0; in_cmt = 0; tok_val = 0;
	endfunction

	function automatic void put_pixel(int rv, int gv, int bv);
		bit fin;
		fin = (col_cnt + 1 >= p_w) && (row_cnt + 1 >= p_h);
		emit(fin ? pnmsd_pkg::KIND_FINAL : pnmsd_pkg::KIND_PIXEL, col_cnt, row_cnt, rv, gv, bv,
			pnmsd_pkg::ERR_NONE);
		if (fin) begin
			ps = S_DONE;
			return;
		end
		col_cnt++;
		if (col_cnt >= p_w) begin
			col_cnt = 0;
			row_cnt++;
		end
	endfunction

	function automatic void start_pixels(parse_t nxt);
		ps = nxt;
		col_cnt = 0; row_cnt = 0; chan = 0; part = 0;
	endfunction

	function automatic void rgb_sample(int v);
		if (chan == 0) begin
			part = v & 255; chan = 1;
		end else if (chan == 1) begin
			part = (part & 255) | ((v & 255) << 8); chan = 2;
		end else begin
			chan = 0;
			put_pixel(part & 255, (part >> 8) & 255, v);
			part = 0;
		end
	endfunction

	function automatic void close_token(logic [7:0] delim);
		int v;
		v = tok_val;
		tok_val = 0;
		in_tok = 0;
		case (ps)
			S_SIG: begin
				if (v != 2) raise_error(pnmsd_pkg::ERR_SIG); else ps = S_WIDTH;
			end
			S_WIDTH: begin
				if (v < 1 || v > DIM_LIMIT) raise_error(pnmsd_pkg::ERR_SIZE);
				else begin p_w = v; ps = S_HEIGHT; end
			end
			S_HEIGHT: begin
				if (v < 1 || v > DIM_LIMIT) raise_error(pnmsd_pkg::ERR_SIZE);
				else begin
					p_h = v;
					if (p_fmt == pnmsd_pkg::FMT_P1 || p_fmt == pnmsd_pkg::FMT_P4) begin
						p_mv = 1;
						emit(pnmsd_pkg::KIND_HEADER, 0, 0, 0, 0, 0, pnmsd_pkg::ERR_NONE);
						if (p_fmt == pnmsd_pkg::FMT_P4)
							start_pixels(delim == pnmsd_pkg::CH_LF ? S_BINPIX : S_SKIPLINE);
						else start_pixels(S_TEXTPIX);
					end else
						ps = S_MAXVAL;
				end
			end
			S_MAXVAL: begin
				if (v < 1 || v > 255) raise_error(pnmsd_pkg::ERR_MAXVAL);
				else begin
					p_mv = v;
					emit(pnmsd_pkg::KIND_HEADER, 0, 0, 0, 0, 0, pnmsd_pkg::ERR_NONE);
					if (p_fmt == pnmsd_pkg::FMT_P2 || p_fmt == pnmsd_pkg::FMT_P3)
						start_pixels(S_TEXTPIX);
					else start_pixels(delim == pnmsd_pkg::CH_LF ? S_BINPIX : S_SKIPLINE);
				end
			end
			S_TEXTPIX: begin
				if (v > 255) raise_error(pnmsd_pkg::ERR_PIXEL);
				else if (p_fmt == pnmsd_pkg::FMT_P3) rgb_sample(v);
				else put_pixel(v, 0, 0);
			end
			default: ;
		endcase
	endfunction

	function automatic void text_char(logic [7:0] c);
		int v;
		if (in_cmt) begin
			if (c == pnmsd_pkg::CH_LF) in_cmt = 0;
			return;
		end
		if (white(c) || c == pnmsd_pkg::CH_HASH) begin
			if (in_tok) close_token(c);
			if (c == pnmsd_pkg::CH_HASH && text_state()) in_cmt = 1;
			return;
		end
		if (ps == S_TEXTPIX && p_fmt == pnmsd_pkg::FMT_P1) begin
			if (c == pnmsd_pkg::CH_0 || c == pnmsd_pkg::CH_1) put_pixel(c - pnmsd_pkg::CH_0, 0, 0);
			else raise_error(pnmsd_pkg::ERR_PIXEL);
			return;
		end
		in_tok = 1;
		if (ps == S_SIG) begin
			if (tok_val == 0 && c == pnmsd_pkg::CH_P) tok_val = 1;
			else if (tok_val == 1 && c >= pnmsd_pkg::CH_1 && c <= pnmsd_pkg::CH_6) begin
				p_fmt = c - pnmsd_pkg::CH_0;
				tok_val = 2;
			end else
				raise_error(pnmsd_pkg::ERR_SIG);
			return;
		end
		if (c < pnmsd_pkg::CH_0 || c > pnmsd_pkg::CH_9) begin
			raise_error(ps == S_MAXVAL ? pnmsd_pkg::ERR_MAXVAL :
				(ps == S_TEXTPIX ? pnmsd_pkg::ERR_PIXEL : pnmsd_pkg::ERR_SIZE));
			return;
		end
		v = tok_val * 10 + (c - pnmsd_pkg::CH_0);
		tok_val = v > 65535 ? 65535 : v;
	endfunction

	function automatic void binary_char(logic [7:0] c, bit eof);
		int n, cap;
		bit completes;
		if (p_fmt == pnmsd_pkg::FMT_P5)
			put_pixel(c, 0, 0);
		else if (p_fmt == pnmsd_pkg::FMT_P6)
			rgb_sample(c);
		else begin
			n = p_w - col_cnt;
			if (n > 8) n = 8;
			completes = (row_cnt + 1 >= p_h) && (col_cnt + n >= p_w);
			cap = (eof && !completes) ? 7 : 8;
			for (int i = 0; i < n && i < cap; i++) begin
				put_pixel((c >> (7 - i)) & 1, 0, 0);
				if (ps != S_BINPIX) break;
			end
		end
	endfunction

	// predict the beats one accepted byte causes and queue them
	function automatic void predict_byte(logic [7:0] c, bit eof);
		byte_beats.delete();
		if (text_state())
			text_char(c);
		else if (ps == S_SKIPLINE) begin
			if (c == pnmsd_pkg::CH_LF) ps = S_BINPIX;
		end else if (ps == S_BINPIX)
			binary_char(c, eof);
		if (eof) begin
			if (in_tok && text_state()) close_token(pnmsd_pkg::CH_LF);
			if (ps != S_DONE && ps != S_ERROR) raise_error(pnmsd_pkg::ERR_EOF);
			shadow_reset();
		end
		if (byte_beats.size() > 0)
			byte_beats[byte_beats.size() - 1].last = 1'b1;
		foreach (byte_beats[i])
			pending_beats.push_back(byte_beats[i]);
	endfunction

	task automatic report(string what, int got, int want);
		mismatches++;
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
	endtask

	// input side: predictor runs on every accepted byte
	always @(posedge clk)
		if (arst_n && in_valid && in_ready)
			predict_byte(data_byte, end_of_file);

	// output side: compare each accepted beat with the oldest prediction
	always @(posedge clk) begin
		pnm_beat_t w;
		if (arst_n && out_valid && out_ready) begin
			beats_seen++;
			if (pending_beats.size() == 0)
				report("unexpected beat kind", kind, -1);
			else begin
				w = pending_beats.pop_front();
				if (kind !== w.kind) report("kind", kind, w.kind);
				if (format !== w.fmt) report("format", format, w.fmt);
				if (width !== w.w) report("width", width, w.w);
				if (height !== w.h) report("height", height, w.h);
				if (max_value !== w.mv) report("max_value", max_value, w.mv);
				if (column !== w.col) report("column", column, w.col);
				if (row !== w.row) report("row", row, w.row);
				if (red_or_gray !== w.r) report("red_or_gray", red_or_gray, w.r);
				if (green !== w.g) report("green", green, w.g);
				if (blue !== w.b) report("blue", blue, w.b);
				if (error_code !== w.err) report("error_code", error_code, w.err);
				if (last !== w.last) report("last", last, w.last);
			end
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one byte beat; called at a rising edge, returns at the edge it is taken
	task automatic send_beat(logic [7:0] b, bit eof);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle && gap < 40) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_file <= eof;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_file();
		foreach (file_buf[i])
			send_beat(file_buf[i], i == file_buf.size() - 1);
		files_sent++;
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
	endtask

	task automatic add_gap();
		case ($urandom_range(9))
			0: add_str("\t");
			1: add_str("\r\n");
			2: add_str("\n");
			3: add_str(" #note\n");
			4: begin file_buf.push_back(pnmsd_pkg::CH_VT); file_buf.push_back(pnmsd_pkg::CH_FF); end
			default: add_str(" ");
		endcase
	endtask

	task automatic add_num(int v);
		add_str($sformatf("%0d", v));
	endtask

	// one well-formed file with random content, sometimes damaged
	task automatic build_file();
		int fmt, w, h, mv, hdr_len, v, nb;
		file_buf.delete();
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, 6)) file_buf.push_back(8'($urandom_range(255)));
			return;
		end
		fmt = ($urandom_range(29) == 0) ? $urandom_range(7) : $urandom_range(1, 6);
		w = $urandom_range(1, 5);
		h = $urandom_range(1, 3);
		case ($urandom_range(39))
			0: w = DIM_LIMIT;
			1: w = DIM_LIMIT + 1;
			2: h = 0;
			default: ;
		endcase
		case ($urandom_range(9))
			0: mv = 1;
			1: mv = 255;
			2: mv = ($urandom_range(3) == 0) ? 256 : 0;
			default: mv = $urandom_range(1, 255);
		endcase
		if ($urandom_range(9) == 0) add_str("#lead\n");
		add_str("P");
		file_buf.push_back(8'(pnmsd_pkg::CH_0 + fmt));
		add_gap(); add_num(w); add_gap(); add_num(h);
		if (fmt != pnmsd_pkg::FMT_P1 && fmt != pnmsd_pkg::FMT_P4) begin
			add_gap(); add_num(mv);
		end
		if (fmt >= pnmsd_pkg::FMT_P4) begin
			case ($urandom_range(5))
				0: add_str(" x\n");
				1: add_str("#c\n");
				default: add_str("\n");
			endcase
		end else
			add_gap();
		hdr_len = file_buf.size();
		case (fmt)
			pnmsd_pkg::FMT_P1: for (int i = 0; i < w * h; i++) begin
				file_buf.push_back($urandom_range(1) ? pnmsd_pkg::CH_1 : pnmsd_pkg::CH_0);
				if ($urandom_range(1)) add_gap();
			end
			pnmsd_pkg::FMT_P2, pnmsd_pkg::FMT_P3:
				for (int i = 0; i < w * h * (fmt == pnmsd_pkg::FMT_P3 ? 3 : 1); i++) begin
					v = $urandom_range(255);
					if ($urandom_range(49) == 0) v = 256;
					if ($urandom_range(79) == 0) v = 123456;
					add_num(v);
					add_gap();
				end
			pnmsd_pkg::FMT_P4: begin
				nb = ((w + 7) / 8) * h;
				repeat (nb) file_buf.push_back(8'($urandom_range(255)));
			end
			pnmsd_pkg::FMT_P5: repeat (w * h) file_buf.push_back(8'($urandom_range(255)));
			pnmsd_pkg::FMT_P6: repeat (3 * w * h) file_buf.push_back(8'($urandom_range(255)));
			default: ;
		endcase
		if (w > 64 && file_buf.size() > hdr_len + 4)
			while (file_buf.size() > hdr_len + 4) void'(file_buf.pop_back());
		v = $urandom_range(99);
		if (v < 15 && file_buf.size() > 2)
			while (file_buf.size() > $urandom_range(1, file_buf.size() - 1))
				void'(file_buf.pop_back());
		else if (v < 25)
			file_buf[$urandom_range(file_buf.size() - 1)] = 8'($urandom_range(255));
		else if (v < 35)
			repeat ($urandom_range(1, 3)) file_buf.push_back(8'($urandom_range(255)));
	endtask

	task automatic wait_drained();
		while (pending_beats.size() != 0) @(posedge clk);
	endtask

	// short hand-made files for the named corner cases
	task automatic test_directed();
		file_buf.delete(); add_str("P7");
		send_file();
		// p4 row of 9 ending early: seven pixels then early end
		file_buf.delete(); add_str("P4 9 1\n"); file_buf.push_back(8'hFF);
		send_file();
		file_buf.delete(); add_str("P2 1 1 256");
		send_file();
		file_buf.delete(); add_str("P5 4097 1");
		send_file();
		file_buf.delete(); add_str("P1 1 1 "); file_buf.push_back(8'h00);
		send_file();
	endtask

	task automatic test_random(int n_bytes, int s_idle, int r_idle);
		int stop_at;
		send_idle = s_idle;
		recv_idle = r_idle;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			build_file();
			send_file();
		end
	endtask

	// receiver holds off while a long binary file keeps coming, then sender waits for drain
	task automatic test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		hold_off = 300;
		file_buf.delete();
		add_str("P5 8 5 255\n");
		repeat (40) file_buf.push_back(8'($urandom_range(255)));
		send_file();
		file_buf.delete();
		add_str("P4 16 2\n");
		repeat (4) file_buf.push_back(8'($urandom_range(255)));
		hold_off = 150;
		send_file();
		in_valid <= 1'b0;
		wait_drained();
	endtask

	initial begin
		shadow_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 0;
		recv_idle = 0;
		test_directed();
		test_random(65, 36, 84);
		test_random(65, 84, 36);
		test_random(65, 0, 0);
		test_backpressure();
		in_valid <= 1'b0;
		wait_drained();
		repeat (30) @(posedge clk);
		$display("covered %0d files, %0d bytes, %0d result beats", files_sent, bytes_sent,
			beats_seen);
		$display("all six formats, header errors, early ends and long output stalls");
		if (mismatches == 0 && pending_beats.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
